@@ src/flh_pkg.sv @@
package flh_pkg;

    localparam int LANES   = 4;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 28;
    localparam int ADDR_W  = 3;

    // register map: index is paddr[2], low address bits are ignored
    localparam logic REG_SEED = 1'b0;

    localparam logic [WORD_W-1:0] MIX_ADD    = 32'hB4DE621A;
    localparam logic [WORD_W-1:0] FMIX_MUL1  = 32'h46AB02EE;
    localparam logic [WORD_W-1:0] FMIX_MUL2  = 32'h7CEBBA4E;

    localparam logic [LANES-1:0][WORD_W-1:0] FIRST_MUL = {
        32'hA329EB99, 32'hBE6214AE, 32'h4DC33A4D, 32'h1FCC49A2
    };
    localparam logic [LANES-1:0][WORD_W-1:0] SECOND_MUL = {
        32'hC9031C00, 32'h4093AEE0, 32'hB33F1B01, 32'hB19CE1AA
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEED,
        OP_KEY1,
        OP_KEY2,
        OP_MIX,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3
    } lane_op_t;

    typedef struct packed {
        lane_op_t          op;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] len;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY2,
        ST_MIX,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_OUT
    } state_t;

endpackage

@@ src/flh_lane.sv @@
module flh_lane
    import flh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] first_mul,
    input  logic [WORD_W-1:0] second_mul,
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] hash_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;

    always_comb
    begin
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] r;
        hash_next = hash_reg;
        acc_next  = acc_reg;
        x = '0;
        r = '0;
        case (ctrl.op)
            OP_SEED:
            begin
                hash_next = ctrl.seed;
            end
            OP_KEY1:
            begin
                acc_next = WORD_W'(word * first_mul);
            end
            OP_KEY2:
            begin
                r        = {acc_reg[16:0], acc_reg[31:17]};   // rotl 15
                acc_next = WORD_W'(r * second_mul);
            end
            OP_MIX:
            begin
                x         = hash_reg ^ acc_reg;
                r         = {x[18:0], x[31:19]};              // rotl 13
                hash_next = WORD_W'((r << 2) + r + MIX_ADD);  // *5 + const
            end
            OP_FIN1:
            begin
                x        = hash_reg ^ ctrl.len;
                r        = x ^ (x >> 16);
                acc_next = WORD_W'(r * FMIX_MUL1);
            end
            OP_FIN2:
            begin
                r        = acc_reg ^ (acc_reg >> 13);
                acc_next = WORD_W'(r * FMIX_MUL2);
            end
            OP_FIN3:
            begin
                acc_next = acc_reg ^ (acc_reg >> 16);
            end
            default:
            begin
                hash_next = hash_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign result = acc_reg;

endmodule

@@ src/flh_merge.sv @@
module flh_merge
    import flh_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [LANES-1:0][WORD_W-1:0] lane_result,
    input  logic                         stall,
    output logic                         valid,
    output logic [WORD_W-1:0]            hash_value
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] folded;

    always_comb
    begin
        folded = '0;
        for (int i = 0; i < LANES; i++)
        begin
            folded = folded ^ lane_result[i];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hash_reg <= folded;
        end
    end

    assign valid      = valid_reg;
    assign hash_value = hash_reg;

endmodule

@@ src/four_lane_block_hash32.sv @@
// Four-lane block hash, 32-bit result.
// Input channel (block_valid / block_stall): one beat carries a 16-byte block
// as word0..word3 (lane 0..3) plus has_block and last. has_block=0 with
// last=1 hashes an empty key; has_block=0 with last=0 is a no-op beat.
// Output channel (hash_valid / hash_stall): one beat per key, sent for every
// input beat with last set. hash_value is held while hash_stall is high.
// Config: APB port, seed at address 0. Writing seed reloads all lanes and
// starts a new key. Write only while the block is idle.
// Steps: one beat at a time through one sequencer shared by all lanes.
//   block only          : two key multiplies, then the lane mix
//   block with last     : key multiplies, lane mix, fmix, fold, then hash_valid
//   empty key (last)    : fmix, fold, then hash_valid
// The fmix chain has two multiplies per lane, each registered.
// block_stall is low only while the sequencer is idle.
// A finished hash waiting on hash_stall does not block the next beat; only a
// new final fold waits for the output register to drain.
// Reset: seed, lane hash state and block count are zero, no beat pending.
module four_lane_block_hash32
    import flh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready,
    // block input
    input  logic              block_valid,
    output logic              block_stall,
    input  logic [WORD_W-1:0] word0,
    input  logic [WORD_W-1:0] word1,
    input  logic [WORD_W-1:0] word2,
    input  logic [WORD_W-1:0] word3,
    input  logic              has_block,
    input  logic              last,
    // hash output
    output logic              hash_valid,
    input  logic              hash_stall,
    output logic [WORD_W-1:0] hash_value
);

    state_t               state_reg;
    state_t               state_next;
    logic [WORD_W-1:0]    seed_reg;
    logic [COUNT_W-1:0]   block_count_reg;
    logic [COUNT_W-1:0]   block_count_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 seed_wr;
    logic                 beat_in;
    logic                 out_free;
    logic                 out_load;
    lane_ctrl_t           lane_ctrl;

    logic [LANES-1:0][WORD_W-1:0] lane_word;
    logic [LANES-1:0][WORD_W-1:0] lane_result;

    // config
    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign prdata  = (paddr[2] == REG_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr)
        begin
            seed_reg <= pwdata;
        end
    end

    assign block_stall = (state_reg != ST_IDLE);
    assign beat_in     = block_valid && !block_stall;
    assign out_free    = !hash_valid || !hash_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (beat_in && has_block)
                begin
                    state_next = ST_KEY2;
                end
                else if (beat_in && last)
                begin
                    state_next = ST_FIN1;
                end
            end
            ST_KEY2: state_next = ST_MIX;
            ST_MIX:  state_next = last_reg ? ST_FIN1 : ST_IDLE;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_FIN3;
            ST_FIN3: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        lane_ctrl.op     = OP_NONE;
        lane_ctrl.seed   = seed_wr ? pwdata : seed_reg;
        lane_ctrl.len    = {block_count_reg, 4'b0000};
        block_count_next = block_count_reg;
        last_next        = last_reg;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (seed_wr)
                begin
                    lane_ctrl.op     = OP_SEED;
                    block_count_next = '0;
                end
                else if (beat_in)
                begin
                    last_next = last;
                    if (has_block)
                    begin
                        lane_ctrl.op = OP_KEY1;
                    end
                end
            end
            ST_KEY2: lane_ctrl.op = OP_KEY2;
            ST_MIX:
            begin
                lane_ctrl.op     = OP_MIX;
                block_count_next = block_count_reg + COUNT_W'(1);
            end
            ST_FIN1: lane_ctrl.op = OP_FIN1;
            ST_FIN2: lane_ctrl.op = OP_FIN2;
            ST_FIN3: lane_ctrl.op = OP_FIN3;
            ST_OUT:
            begin
                if (out_free)
                begin
                    // fold goes out, lanes restart from seed
                    out_load         = 1'b1;
                    lane_ctrl.op     = OP_SEED;
                    block_count_next = '0;
                end
            end
            default: lane_ctrl.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            last_reg        <= last_next;
        end
    end

    assign lane_word[0] = word0;
    assign lane_word[1] = word1;
    assign lane_word[2] = word2;
    assign lane_word[3] = word3;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        flh_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .word       (lane_word[i]),
            .first_mul  (FIRST_MUL[i]),
            .second_mul (SECOND_MUL[i]),
            .result     (lane_result[i])
        );
    end

    flh_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .lane_result (lane_result),
        .stall       (hash_stall),
        .valid       (hash_valid),
        .hash_value  (hash_value)
    );

    // a beat carrying a block always starts the key multiply sequence
    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_in && has_block) |=> (state_reg == ST_KEY2))
        else $error("block beat did not enter key sequence");

    // each lane mix advances the block count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX) |=> (block_count_reg == $past(block_count_reg + COUNT_W'(1))))
        else $error("block count did not advance on mix");

    // a new hash beat appears only after the fold state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(state_reg == ST_OUT))
        else $error("hash beat raised outside fold");

    // a seed write starts a new key
    a_seed_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (seed_wr && (state_reg == ST_IDLE)) |=> (block_count_reg == '0))
        else $error("seed write did not clear block count");

endmodule

@@ test/tb_four_lane_block_hash32.sv @@
`timescale 1ns / 100ps

// Testbench for the four-lane block hash.
// Blocks are streamed into the block channel as keys (runs of blocks closed
// by a beat with last set). An independent lane-by-lane predictor runs on
// every accepted beat and queues the hash each key should produce. The
// checker compares every accepted hash beat with the oldest queued hash.
// The seed register is rewritten between phases, only once the block has
// drained. Both sides insert random gaps; one phase holds the output off
// long enough to back the block up into its input.
module tb_four_lane_block_hash32;
    import flh_pkg::*;

    localparam int SETTLE_CYCLES = 16;   // covers the block+last path
    localparam int HOLD_CYCLES   = 200;  // long output hold-off
    localparam int RAND_ITEMS    = 195;  // per random phase, four phases

    // seed at byte address 0, unused register slot at 4
    localparam logic [ADDR_W-1:0] ADDR_SEED   = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4);

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;
    logic              block_valid;
    logic              block_stall;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;
    logic              has_block;
    logic              last;
    logic              hash_valid;
    logic              hash_stall;
    logic [WORD_W-1:0] hash_value;

    // output stall is the OR of the per-beat random stall and the hold-off
    logic rand_stall = 1'b0;
    logic hold_stall = 1'b0;
    assign hash_stall = rand_stall | hold_stall;

    // gap limits, changed per phase (0 gives stretches with no idling)
    int send_gap_max  = 19;
    int stall_gap_max = 19;

    // predictor state
    logic [31:0] seed_m;
    logic [31:0] lane_m [4];
    logic [27:0] blocks_m;
    logic [31:0] hash_q [$];   // hashes still owed by the block

    int n_items;
    int n_keys;
    int n_blocks;
    int n_seeds;
    int n_checked;
    int n_errors;

    four_lane_block_hash32 DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .word0       (word0),
        .word1       (word1),
        .word2       (word2),
        .word3       (word3),
        .has_block   (has_block),
        .last        (last),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall),
        .hash_value  (hash_value)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // per-lane key multipliers, lane 0 first
    function automatic logic [31:0] key_mul_a(input int lane);
        case (lane)
            0:       return 32'h1FCC49A2;
            1:       return 32'h4DC33A4D;
            2:       return 32'hBE6214AE;
            default: return 32'hA329EB99;
        endcase
    endfunction

    function automatic logic [31:0] key_mul_b(input int lane);
        case (lane)
            0:       return 32'hB19CE1AA;
            1:       return 32'hB33F1B01;
            2:       return 32'h4093AEE0;
            default: return 32'hC9031C00;
        endcase
    endfunction

    function automatic logic [31:0] fmix_lane(input logic [31:0] h, input logic [31:0] len);
        logic [31:0] x;
        x = h ^ len;
        x = x ^ (x >> 16);
        x = x * 32'h46AB02EE;
        x = x ^ (x >> 13);
        x = x * 32'h7CEBBA4E;
        x = x ^ (x >> 16);
        return x;
    endfunction

    task automatic restart_lanes();
        for (int i = 0; i < 4; i++)
            lane_m[i] = seed_m;
        blocks_m = '0;
    endtask

    // advance the predictor by one accepted beat; queue a hash on last
    task automatic absorb_beat(input logic [3:0][31:0] words, input logic hb, input logic lst);
        logic [31:0] k;
        logic [31:0] folded;
        if (hb)
        begin
            for (int i = 0; i < 4; i++)
            begin
                k = words[i] * key_mul_a(i);
                k = rotl32(k, 15);
                k = k * key_mul_b(i);
                lane_m[i] = rotl32(lane_m[i] ^ k, 13) * 32'd5 + 32'hB4DE621A;
            end
            blocks_m = blocks_m + 28'd1;
        end
        if (lst)
        begin
            folded = '0;
            for (int i = 0; i < 4; i++)
                folded = folded ^ fmix_lane(lane_m[i], {blocks_m, 4'b0000});
            hash_q.push_back(folded);
            restart_lanes();
        end
    endtask

    // ------------------------------------------------------------------
    // Config port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // register index is the word address; only index 0 exists
        if ((addr >> 2) == 0)
        begin
            seed_m = data;
            restart_lanes();
            n_seeds++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: seed readback expected %08h actual %08h", $time, want, prdata);
            n_errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Block channel
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [3:0][31:0] words, input logic hb, input logic lst);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            @(negedge clk);
            block_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        word0       <= words[0];
        word1       <= words[1];
        word2       <= words[2];
        word3       <= words[3];
        has_block   <= hb;
        last        <= lst;
        block_valid <= 1'b1;
        do @(posedge clk); while (block_stall);
        absorb_beat(words, hb, lst);
        if (hb || lst)
            n_items++;
        if (hb)
            n_blocks++;
        if (lst)
            n_keys++;
    endtask

    // mostly random words, with some all-zero, all-one and one-hot words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0][31:0] pick_block();
        logic [3:0][31:0] b;
        for (int i = 0; i < 4; i++)
            b[i] = pick_word();
        return b;
    endfunction

    // one key of nblk blocks; split_last closes it with a separate empty beat
    task automatic send_key(input int nblk, input bit split_last);
        for (int i = 0; i < nblk; i++)
            send_beat(pick_block(), 1'b1, (i == nblk - 1) && !split_last);
        if (nblk == 0 || split_last)
            send_beat('0, 1'b0, 1'b1);
    endtask

    // stop offering, let every owed hash out, then give the block time to
    // finish a beat that owes nothing
    task automatic drain();
        @(negedge clk);
        block_valid <= 1'b0;
        while (hash_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Hash channel: random stall per beat, and the checker
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int n;
        forever
        begin
            n = $urandom_range(0, stall_gap_max);
            if (n > 0)
            begin
                @(negedge clk);
                rand_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            rand_stall <= 1'b0;
            do @(posedge clk); while (!(hash_valid && !hash_stall));
        end
    end

    // long hold-off, counted here while the sender keeps offering
    task automatic hold_output(input int cycles);
        @(negedge clk);
        hold_stall <= 1'b1;
        repeat (cycles - 1) @(negedge clk);
        @(negedge clk);
        hold_stall <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && hash_valid && !hash_stall)
        begin
            if (hash_q.size() == 0)
            begin
                $display("%0t: hash beat with none owed, expected none actual %08h",
                         $time, hash_value);
                n_errors++;
            end
            else
            begin
                if (hash_value !== hash_q[0])
                begin
                    $display("%0t: hash_value expected %08h actual %08h",
                             $time, hash_q[0], hash_value);
                    n_errors++;
                end
                void'(hash_q.pop_front());
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // seed resets to zero; empty key on the reset lanes
    task automatic test_reset_state();
        apb_read_check(ADDR_SEED, 32'h0);
        send_beat('0, 1'b0, 1'b1);
        drain();
    endtask

    // extreme words, block+last in one beat vs block then empty last
    task automatic test_field_extremes();
        send_beat({4{32'h0000_0000}}, 1'b1, 1'b1);
        send_beat({4{32'hFFFF_FFFF}}, 1'b1, 1'b1);
        send_beat({32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b1, 1'b1);
        send_beat({32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, 1'b0);
        send_beat({32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF}, 1'b1, 1'b0);
        send_beat('0, 1'b0, 1'b1);
        drain();
    endtask

    // idle beats (no block, no last) must leave the key untouched
    task automatic test_idle_beats();
        send_beat(pick_block(), 1'b1, 1'b0);
        send_beat({4{32'hFFFF_FFFF}}, 1'b0, 1'b0);
        send_beat(pick_block(), 1'b0, 1'b0);
        send_beat(pick_block(), 1'b1, 1'b1);
        send_beat({4{32'hFFFF_FFFF}}, 1'b0, 1'b0);
        drain();
    endtask

    // seed write in the middle of a key drops the partial key
    task automatic test_seed_restart();
        logic [31:0] s;
        s = $urandom;
        send_beat(pick_block(), 1'b1, 1'b0);
        send_beat(pick_block(), 1'b1, 1'b0);
        drain();
        apb_write(ADDR_SEED, s);
        apb_read_check(ADDR_SEED, s);
        send_beat(pick_block(), 1'b1, 1'b1);
        send_beat('0, 1'b0, 1'b1);
        drain();
    endtask

    // a write outside the register map changes nothing, key goes on
    task automatic test_ignored_register();
        send_beat(pick_block(), 1'b1, 1'b0);
        drain();
        apb_write(ADDR_UNUSED, $urandom);
        apb_read_check(ADDR_SEED, seed_m);
        send_beat(pick_block(), 1'b1, 1'b1);
        drain();
    endtask

    // random keys under one seed and one pair of gap limits; a few noise
    // beats (idle beats, stray blocks, empty keys) are mixed in
    task automatic test_random_keys(input logic [31:0] s, input int gap_s, input int gap_r);
        int goal;
        int nblk;
        goal = n_items + RAND_ITEMS;
        apb_write(ADDR_SEED, s);
        send_gap_max  = gap_s;
        stall_gap_max = gap_r;
        while (n_items < goal)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                case ($urandom_range(0, 2))
                    0:       send_beat(pick_block(), 1'b0, 1'b0);
                    1:       send_beat(pick_block(), 1'b1, 1'b0);
                    default: send_beat(pick_block(), 1'b0, 1'b1);
                endcase
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    nblk = $urandom_range(6, 12);
                else
                    nblk = $urandom_range(0, 4);
                send_key(nblk, $urandom_range(0, 3) == 0);
            end
        end
        drain();
    endtask

    // output held off while the sender streams short keys back to back
    task automatic test_backpressure();
        send_gap_max  = 0;
        stall_gap_max = 3;
        fork
            hold_output(HOLD_CYCLES);
        join_none
        for (int i = 0; i < 30; i++)
            send_key($urandom_range(0, 2), 1'b0);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        block_valid = 1'b0;
        word0       = '0;
        word1       = '0;
        word2       = '0;
        word3       = '0;
        has_block   = 1'b0;
        last        = 1'b0;
        n_items     = 0;
        n_keys      = 0;
        n_blocks    = 0;
        n_seeds     = 0;
        n_checked   = 0;
        n_errors    = 0;
        seed_m      = '0;
        restart_lanes();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_idle_beats();
        test_seed_restart();
        test_ignored_register();

        test_random_keys($urandom, 19, 19);
        test_random_keys(32'h0000_0000, 0, 0);
        test_random_keys(32'hFFFF_FFFF, 0, 19);
        test_random_keys($urandom, 19, 0);

        test_backpressure();

        $display("Covered %0d keys from %0d blocks (%0d counted beats) over %0d seed writes,",
                 n_keys, n_blocks, n_items, n_seeds);
        $display("incl. empty keys, idle beats, mid-key reseed and a long output hold-off;"
                 , " %0d hashes checked", n_checked);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #1_000_000;
        $display("%0t: timeout with %0d hashes still owed", $time, hash_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
